// ----- hdl/nsr_pkg.sv -----
package nsr_pkg;

  // Longest sentence held by one message buffer, and length of the type field.
  localparam int unsigned MAXLEN   = 128;
  localparam int unsigned TYPE_LEN = 5;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Characters that the parser recognizes.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_V      = 8'h56;

  // Buffer codes as the reader reports them; the active buffer uses them too.
  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_GGA  = 3'd1;
  localparam logic [2:0] RD_RMC  = 3'd2;
  localparam logic [2:0] RD_GSA  = 3'd3;
  localparam logic [2:0] RD_GSV  = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] reader_buffer;
  } in_t;

  typedef struct packed {
    logic       write_valid;
    logic [1:0] write_buffer;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic       message_done;
    logic [1:0] done_buffer;
    logic [7:0] overflow_count;
    logic       last_result;
  } out_t;

  // One command per accepted byte. A completing command expands into
  // three results in the back part.
  typedef struct packed {
    logic       wr_valid;
    logic [1:0] wr_buffer;
    logic [7:0] wr_index;
    logic [7:0] wr_data;
    logic       complete;
    logic [7:0] checksum;
    logic [7:0] skip_count;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- hdl/nmea_sentence_router.sv -----
// An accepted byte is written into the command queue; its first result appears at the queue head.
// One byte per cycle is taken while the queue is not full; a byte ending a sentence yields three
// results (LF, terminator, checksum), and the four-entry command queue absorbs that burst.
// Reset (rst_ni low, asynchronous) returns the parser to hunting for '$', clears the
// checksum, the active buffer, the clash counter, the queue and the satellite enable.
module nmea_sentence_router (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nsr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output nsr_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_data_i
);

  // The front part parses every accepted byte in the cycle it arrives and turns it into
  // one command. All sentence state (hunting, index, checksum, routing) lives there, so
  // parsing never waits on the output side except when the queue is full.
  nsr_pkg::cmd_t    push_cmd;
  nsr_pkg::cmd_t    head_cmd;
  nsr_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  nsr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // The queue decouples the two sides: input transfers continue while a completed
  // sentence is still draining its three results.
  nsr_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  // The back part presents the queue head as a result and steps through the
  // terminator and checksum writes of a completing command before popping it.
  nsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .pop_o       (pop)
  );

endmodule

// ----- hdl/nsr_front.sv -----
module nsr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  nsr_pkg::in_t     in_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  nsr_pkg::q_stat_t q_stat_i,
  output logic             in_stall_o,
  output logic             push_o,
  output nsr_pkg::cmd_t    cmd_o
);

  logic       want_sat_q;
  logic       hunting_q, hunting_d;
  logic [7:0] byte_index_q, byte_index_d;
  logic [7:0] xor_q, xor_d;
  logic       xor_active_q, xor_active_d;
  logic [2:0] active_q, active_d;
  logic [7:0] skip_q, skip_d;
  logic [7:0] type_c2_q, type_c3_q;

  logic       accept;
  logic [7:0] ch;
  logic       xa;
  logic [8:0] next_index;
  logic [2:0] sel;

  assign accept     = in_valid_i & ~q_stat_i.full;
  assign in_stall_o = q_stat_i.full;
  assign push_o     = accept;
  assign ch         = in_data_i.rx_byte;
  assign next_index = {1'b0, byte_index_q} + 9'd1;

  // Type routing on the last type character, which is the current byte.
  always_comb begin
    sel = nsr_pkg::RD_NONE;
    if (type_c2_q == nsr_pkg::CH_G && type_c3_q == nsr_pkg::CH_G && ch == nsr_pkg::CH_A) begin
      sel = nsr_pkg::RD_GGA;
    end else if (type_c2_q == nsr_pkg::CH_R && type_c3_q == nsr_pkg::CH_M
                 && ch == nsr_pkg::CH_C) begin
      sel = nsr_pkg::RD_RMC;
    end else if (want_sat_q && type_c2_q == nsr_pkg::CH_G && type_c3_q == nsr_pkg::CH_S) begin
      if (ch == nsr_pkg::CH_A) begin
        sel = nsr_pkg::RD_GSA;
      end else if (ch == nsr_pkg::CH_V) begin
        sel = nsr_pkg::RD_GSV;
      end
    end
  end

  always_comb begin
    hunting_d    = hunting_q;
    byte_index_d = byte_index_q;
    xor_d        = xor_q;
    xor_active_d = xor_active_q;
    active_d     = active_q;
    skip_d       = skip_q;
    xa           = xor_active_q;
    cmd_o        = '0;

    if (hunting_q) begin
      if (ch == nsr_pkg::CH_DOLLAR) begin
        if (in_data_i.reader_buffer != nsr_pkg::RD_NONE
            && in_data_i.reader_buffer == active_q) begin
          skip_d = skip_q + 8'd1;
        end else begin
          hunting_d    = 1'b0;
          xor_d        = '0;
          xor_active_d = 1'b1;
          byte_index_d = '0;
        end
      end
    end else begin
      if (ch == nsr_pkg::CH_STAR) begin
        xa = 1'b0;
      end
      xor_active_d = xa;
      if (xa) begin
        xor_d = xor_q ^ ch;
      end
      byte_index_d = next_index[7:0];

      if (byte_index_q < 8'(nsr_pkg::TYPE_LEN)) begin
        if (next_index == 9'(nsr_pkg::TYPE_LEN)) begin
          if (sel != nsr_pkg::RD_NONE) begin
            active_d = sel;
          end else begin
            hunting_d = 1'b1;
          end
        end else if (ch == nsr_pkg::CH_LF) begin
          hunting_d = 1'b1;
        end
      end else begin
        cmd_o.wr_valid  = 1'b1;
        cmd_o.wr_buffer = 2'(active_q - 3'd1);
        cmd_o.wr_index  = byte_index_q;
        cmd_o.wr_data   = ch;
        if (next_index >= 9'(nsr_pkg::MAXLEN)) begin
          hunting_d = 1'b1;
        end else if (ch == nsr_pkg::CH_LF) begin
          hunting_d      = 1'b1;
          cmd_o.complete = 1'b1;
          cmd_o.checksum = xor_d;
        end
      end
    end
    cmd_o.skip_count = skip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_sat_q   <= 1'b0;
      hunting_q    <= 1'b1;
      byte_index_q <= '0;
      xor_q        <= '0;
      xor_active_q <= 1'b0;
      active_q     <= nsr_pkg::RD_NONE;
      skip_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        want_sat_q <= cfg_data_i;
      end
      if (accept) begin
        hunting_q    <= hunting_d;
        byte_index_q <= byte_index_d;
        xor_q        <= xor_d;
        xor_active_q <= xor_active_d;
        active_q     <= active_d;
        skip_q       <= skip_d;
      end
    end
  end

  // Routing uses only the third, fourth and fifth type characters; the third and fourth are held here.
  always_ff @(posedge clk_i) begin
    if (accept && !hunting_q) begin
      if (byte_index_q == 8'd2) begin
        type_c2_q <= ch;
      end
      if (byte_index_q == 8'd3) begin
        type_c3_q <= ch;
      end
    end
  end

endmodule

// ----- hdl/nsr_cmd_fifo.sv -----
module nsr_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nsr_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output nsr_pkg::cmd_t    head_o,
  output nsr_pkg::q_stat_t stat_o
);

  nsr_pkg::cmd_t                   entry_q [nsr_pkg::CMD_DEPTH];
  logic [nsr_pkg::CMD_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [nsr_pkg::CMD_CNT_W-1:0]   count_q;

  function automatic logic [nsr_pkg::CMD_PTR_W-1:0] ptr_inc(
    input logic [nsr_pkg::CMD_PTR_W-1:0] p
  );
    return (p == nsr_pkg::CMD_PTR_W'(nsr_pkg::CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == nsr_pkg::CMD_CNT_W'(nsr_pkg::CMD_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hdl/nsr_back.sv -----
module nsr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsr_pkg::cmd_t    head_i,
  input  nsr_pkg::q_stat_t q_stat_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output nsr_pkg::out_t    out_data_o,
  output logic             pop_o
);

  typedef enum logic [1:0] {
    PH_BODY,
    PH_TERM,
    PH_SUM
  } phase_e;

  phase_e phase_q;
  logic   fire;

  assign out_valid_o = ~q_stat_i.empty;
  assign fire        = out_valid_o & ~out_stall_i;
  assign pop_o       = fire & out_data_o.last_result;

  always_comb begin
    out_data_o                = '0;
    out_data_o.overflow_count = head_i.skip_count;
    unique case (phase_q)
      PH_BODY: begin
        out_data_o.write_valid  = head_i.wr_valid;
        out_data_o.write_buffer = head_i.wr_buffer;
        out_data_o.write_index  = head_i.wr_index;
        out_data_o.write_data   = head_i.wr_data;
        out_data_o.last_result  = ~head_i.complete;
      end
      PH_TERM: begin
        out_data_o.write_valid  = 1'b1;
        out_data_o.write_buffer = head_i.wr_buffer;
        out_data_o.write_index  = head_i.wr_index + 8'd1;
        out_data_o.write_data   = nsr_pkg::CH_NUL;
      end
      PH_SUM: begin
        out_data_o.write_valid  = 1'b1;
        out_data_o.write_buffer = head_i.wr_buffer;
        out_data_o.write_index  = head_i.wr_index + 8'd2;
        out_data_o.write_data   = head_i.checksum;
        out_data_o.message_done = 1'b1;
        out_data_o.done_buffer  = head_i.wr_buffer;
        out_data_o.last_result  = 1'b1;
      end
      default: begin
        out_data_o.last_result = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BODY;
    end else if (fire) begin
      unique case (phase_q)
        PH_BODY: phase_q <= out_data_o.last_result ? PH_BODY : PH_TERM;
        PH_TERM: phase_q <= PH_SUM;
        default: phase_q <= PH_BODY;
      endcase
    end
  end

endmodule

// ----- hdl/nsr_checker.sv -----
module nsr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input nsr_pkg::out_t out_data_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // The follow-on writes of a completing sentence are ready at once.
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_result) |=> out_valid_o)
    else $error("sentence completion burst broken");

  // All results of one byte report the same clash count.
  a_skip_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_result)
      |=> out_data_o.overflow_count == $past(out_data_o.overflow_count))
    else $error("clash count changed within one byte");

  // Completion is the last result and writes the checksum into the same buffer.
  a_done_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.message_done)
      |-> (out_data_o.last_result && out_data_o.write_valid
           && out_data_o.done_buffer == out_data_o.write_buffer))
    else $error("malformed completion result");

endmodule

bind nmea_sentence_router nsr_checker u_nsr_checker (.*);
